### hw/rtl/zgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zonotope generator slicer package
// Shared widths, dimension codes, item types, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package zgs_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int ACC_WIDTH   = 48;
   localparam int CODE_WIDTH  = 8;
   localparam int LAMBDA_FRAC = 30;
   localparam int DIV_CNT_W   = $clog2(LAMBDA_FRAC);
   localparam int GEN_COUNT   = 3;
   localparam int GEN_W       = $clog2(GEN_COUNT);
   localparam int PROD_W      = 2 * DATA_WIDTH;

   // dimension codes
   localparam logic [CODE_WIDTH-1:0] DIM_U    = CODE_WIDTH'(7);
   localparam logic [CODE_WIDTH-1:0] DIM_V    = CODE_WIDTH'(8);
   localparam logic [CODE_WIDTH-1:0] DIM_R    = CODE_WIDTH'(9);
   localparam logic [CODE_WIDTH-1:0] DIM_XY_A = CODE_WIDTH'(11);
   localparam logic [CODE_WIDTH-1:0] DIM_XY_B = CODE_WIDTH'(12);

   // lambda magnitude constants (Q2.30)
   localparam logic [DATA_WIDTH-1:0] Q_ONE     = DATA_WIDTH'(1) << LAMBDA_FRAC;
   localparam logic [DATA_WIDTH-1:0] Q_SNAP    = Q_ONE + DATA_WIDTH'(1);
   localparam logic [DATA_WIDTH-1:0] Q_SAT_NEG = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] Q_SAT_POS = Q_SAT_NEG - DATA_WIDTH'(1);

   localparam logic [GEN_W-1:0]     GEN_LAST = GEN_W'(GEN_COUNT - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(LAMBDA_FRAC - 1);

   typedef struct packed {
      logic        [CODE_WIDTH-1:0] dim_code;
      logic signed [DATA_WIDTH-1:0] ctr_val;
      logic signed [DATA_WIDTH-1:0] slice_val;
      logic signed [DATA_WIDTH-1:0] gen_x;
      logic signed [DATA_WIDTH-1:0] gen_y;
      logic signed [DATA_WIDTH-1:0] gen_h;
      logic signed [DATA_WIDTH-1:0] point_u;
      logic signed [DATA_WIDTH-1:0] point_v;
      logic signed [DATA_WIDTH-1:0] point_r;
      logic                         last_gen;
   } req_item_type;

   typedef struct packed {
      logic signed [ACC_WIDTH-1:0]  sum_x;
      logic signed [ACC_WIDTH-1:0]  sum_y;
      logic signed [ACC_WIDTH-1:0]  sum_h;
      logic                         lambda_ok;
      logic                         xy_found;
      logic signed [DATA_WIDTH-1:0] xy_gen_x;
      logic signed [DATA_WIDTH-1:0] xy_gen_y;
      logic signed [DATA_WIDTH-1:0] xy_gen_h;
      logic signed [DATA_WIDTH-1:0] xy_slice_val;
      logic signed [DATA_WIDTH-1:0] xy_ctr_val;
      logic                         bad_dim;
   } rsp_item_type;

   typedef enum logic [1:0] {
      KIND_XY,
      KIND_LAMBDA,
      KIND_BAD
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_INIT,
      S_DIV,
      S_SNAP,
      S_MUL,
      S_ACC,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             prep;
      logic             init;
      logic             div_step;
      logic             snap;
      logic             mul;
      logic             acc;
      logic             emit;
      logic [GEN_W-1:0] gen_sel;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     slice_zero;
      logic     sat;
      logic     last;
      logic     out_busy;
   } stat_type;

   function automatic kind_type classify(input logic [CODE_WIDTH-1:0] code);
      kind_type k;
      unique case (code) inside
         DIM_XY_A, DIM_XY_B:   k = KIND_XY;
         DIM_U, DIM_V, DIM_R:  k = KIND_LAMBDA;
         default:              k = KIND_BAD;
      endcase
      return k;
   endfunction

endpackage

### hw/rtl/zgs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zonotope generator slicer controller
// Sequences one item at a time: classify, divide, snap, weigh and emit.
// ----------------------------------------------------------------------------
module zgs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  zgs_pkg::stat_type stat,
   output zgs_pkg::cmd_type  cmd
);
   import zgs_pkg::*;

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [GEN_W-1:0]      gen_ff, gen_in;
   state_type             done_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
         gen_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
         gen_ff     <= gen_in;
      end
   end

   assign done_state = stat.last ? S_EMIT : S_IDLE;

   // next state
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      gen_in     = gen_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_PREP;
         end
         S_PREP: begin
            if (stat.kind == KIND_LAMBDA && !stat.slice_zero) state_in = S_INIT;
            else state_in = done_state;
         end
         S_INIT: begin
            div_cnt_in = '0;
            state_in   = stat.sat ? S_SNAP : S_DIV;
         end
         S_DIV: begin
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) state_in = S_SNAP;
         end
         S_SNAP: begin
            gen_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if (gen_ff == GEN_LAST) begin
               state_in = done_state;
            end else begin
               gen_in   = gen_ff + GEN_W'(1);
               state_in = S_MUL;
            end
         end
         S_EMIT: begin
            if (!stat.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.gen_sel = gen_ff;
      req_stall   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_PREP:  cmd.prep     = 1'b1;
         S_INIT:  cmd.init     = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_SNAP:  cmd.snap     = 1'b1;
         S_MUL:   cmd.mul      = 1'b1;
         S_ACC:   cmd.acc      = 1'b1;
         S_EMIT:  cmd.emit     = !stat.out_busy;
         default: req_stall    = 1'b1;
      endcase
   end

endmodule

### hw/rtl/zgs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zonotope generator slicer datapath
// Item latch, restoring divider, shared multiplier, saturating accumulators,
// xy slice store and the result register.
// ----------------------------------------------------------------------------
module zgs_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  zgs_pkg::req_item_type req_item,
   input  zgs_pkg::cmd_type      cmd,
   output zgs_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output zgs_pkg::rsp_item_type rsp_item
);
   import zgs_pkg::*;

   req_item_type            item_ff;
   logic [DATA_WIDTH-1:0]   n_ff, n_in;
   logic [DATA_WIDTH-1:0]   d_ff, d_in;
   logic                    neg_ff, neg_in;
   logic [DATA_WIDTH-1:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]   q_ff, q_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    gneg_ff, gneg_in;
   logic [ACC_WIDTH-1:0]    acc_x_ff, acc_x_in;
   logic [ACC_WIDTH-1:0]    acc_y_ff, acc_y_in;
   logic [ACC_WIDTH-1:0]    acc_h_ff, acc_h_in;
   logic                    all_ok_ff, all_ok_in;
   logic                    xy_seen_ff, xy_seen_in;
   logic                    dim_err_ff, dim_err_in;
   logic [DATA_WIDTH-1:0]   xy_x_ff, xy_x_in;
   logic [DATA_WIDTH-1:0]   xy_y_ff, xy_y_in;
   logic [DATA_WIDTH-1:0]   xy_h_ff, xy_h_in;
   logic [DATA_WIDTH-1:0]   xy_s_ff, xy_s_in;
   logic [DATA_WIDTH-1:0]   xy_c_ff, xy_c_in;
   rsp_item_type            rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   kind_type                kind;
   logic [DATA_WIDTH-1:0]   pt;
   logic [DATA_WIDTH:0]     diff, diff_neg;
   logic [DATA_WIDTH:0]     rem2;
   logic                    q0, ge;
   logic [DATA_WIDTH-1:0]   gsel, gmag;
   logic [DATA_WIDTH:0]     tmag;
   logic [ACC_WIDTH:0]      tval, acc_ext, sum;
   logic [ACC_WIDTH-1:0]    acc_cur, acc_new;

   assign kind = classify(item_ff.dim_code);

   always_comb begin
      case (item_ff.dim_code)
         DIM_U:   pt = item_ff.point_u;
         DIM_V:   pt = item_ff.point_v;
         default: pt = item_ff.point_r;
      endcase
   end

   assign diff     = {pt[DATA_WIDTH-1], pt}
                   - {item_ff.ctr_val[DATA_WIDTH-1], item_ff.ctr_val};
   assign diff_neg = -diff;

   assign q0   = n_ff >= d_ff;
   assign rem2 = {rem_ff, 1'b0};
   assign ge   = rem2 >= {1'b0, d_ff};

   always_comb begin
      case (cmd.gen_sel)
         2'd0:    gsel = item_ff.gen_x;
         2'd1:    gsel = item_ff.gen_y;
         default: gsel = item_ff.gen_h;
      endcase
   end
   assign gmag = gsel[DATA_WIDTH-1] ? (~gsel + DATA_WIDTH'(1)) : gsel;

   always_comb begin
      case (cmd.gen_sel)
         2'd0:    acc_cur = acc_x_ff;
         2'd1:    acc_cur = acc_y_ff;
         default: acc_cur = acc_h_ff;
      endcase
   end

   // drop the 30 lambda fraction bits, apply sign, add with saturation
   assign tmag    = prod_ff[LAMBDA_FRAC+DATA_WIDTH:LAMBDA_FRAC];
   assign tval    = (neg_ff ^ gneg_ff) ? -(ACC_WIDTH+1)'(tmag) : (ACC_WIDTH+1)'(tmag);
   assign acc_ext = {acc_cur[ACC_WIDTH-1], acc_cur};
   assign sum     = acc_ext + tval;
   always_comb begin
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
         acc_new = {sum[ACC_WIDTH], {(ACC_WIDTH-1){~sum[ACC_WIDTH]}}};
      else
         acc_new = sum[ACC_WIDTH-1:0];
   end

   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      gneg_in      = gneg_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      acc_h_in     = acc_h_ff;
      all_ok_in    = all_ok_ff;
      xy_seen_in   = xy_seen_ff;
      dim_err_in   = dim_err_ff;
      xy_x_in      = xy_x_ff;
      xy_y_in      = xy_y_ff;
      xy_h_in      = xy_h_ff;
      xy_s_in      = xy_s_ff;
      xy_c_in      = xy_c_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.prep) begin
         n_in   = diff[DATA_WIDTH] ? diff_neg[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
         d_in   = item_ff.slice_val[DATA_WIDTH-1]
                ? (~item_ff.slice_val + DATA_WIDTH'(1)) : item_ff.slice_val;
         neg_in = diff[DATA_WIDTH] ^ item_ff.slice_val[DATA_WIDTH-1];
         case (kind)
            KIND_XY: begin
               xy_x_in    = item_ff.gen_x;
               xy_y_in    = item_ff.gen_y;
               xy_h_in    = item_ff.gen_h;
               xy_s_in    = item_ff.slice_val;
               xy_c_in    = item_ff.ctr_val;
               xy_seen_in = 1'b1;
            end
            KIND_LAMBDA: begin
               if (stat.slice_zero) all_ok_in = 1'b0;
            end
            default: dim_err_in = 1'b1;
         endcase
      end

      if (cmd.init) begin
         if (stat.sat) begin
            q_in = neg_ff ? Q_SAT_NEG : Q_SAT_POS;
         end else begin
            q_in   = {{(DATA_WIDTH-1){1'b0}}, q0};
            rem_in = q0 ? (n_ff - d_ff) : n_ff;
         end
      end

      if (cmd.div_step) begin
         rem_in = ge ? DATA_WIDTH'(rem2 - {1'b0, d_ff}) : rem2[DATA_WIDTH-1:0];
         q_in   = {q_ff[DATA_WIDTH-2:0], ge};
      end

      if (cmd.snap) begin
         if (q_ff == Q_SNAP) q_in = Q_ONE;
         else if (q_ff > Q_ONE) all_ok_in = 1'b0;
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(q_ff) * PROD_W'(gmag);
         gneg_in = gsel[DATA_WIDTH-1];
      end

      if (cmd.acc) begin
         case (cmd.gen_sel)
            2'd0:    acc_x_in = acc_new;
            2'd1:    acc_y_in = acc_new;
            default: acc_h_in = acc_new;
         endcase
      end

      if (cmd.emit) begin
         rsp_in.sum_x        = acc_x_ff;
         rsp_in.sum_y        = acc_y_ff;
         rsp_in.sum_h        = acc_h_ff;
         rsp_in.lambda_ok    = all_ok_ff;
         rsp_in.xy_found     = xy_seen_ff;
         rsp_in.xy_gen_x     = xy_x_ff;
         rsp_in.xy_gen_y     = xy_y_ff;
         rsp_in.xy_gen_h     = xy_h_ff;
         rsp_in.xy_slice_val = xy_s_ff;
         rsp_in.xy_ctr_val   = xy_c_ff;
         rsp_in.bad_dim      = dim_err_ff;
         rsp_valid_in        = 1'b1;
         // start the next query from reset values
         acc_x_in   = '0;
         acc_y_in   = '0;
         acc_h_in   = '0;
         all_ok_in  = 1'b1;
         xy_seen_in = 1'b0;
         dim_err_in = 1'b0;
         xy_x_in    = '0;
         xy_y_in    = '0;
         xy_h_in    = '0;
         xy_s_in    = '0;
         xy_c_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_h_ff     <= '0;
         all_ok_ff    <= 1'b1;
         xy_seen_ff   <= 1'b0;
         dim_err_ff   <= 1'b0;
         xy_x_ff      <= '0;
         xy_y_ff      <= '0;
         xy_h_ff      <= '0;
         xy_s_ff      <= '0;
         xy_c_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         acc_h_ff     <= acc_h_in;
         all_ok_ff    <= all_ok_in;
         xy_seen_ff   <= xy_seen_in;
         dim_err_ff   <= dim_err_in;
         xy_x_ff      <= xy_x_in;
         xy_y_ff      <= xy_y_in;
         xy_h_ff      <= xy_h_in;
         xy_s_ff      <= xy_s_in;
         xy_c_ff      <= xy_c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_item;
      n_ff    <= n_in;
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
      gneg_ff <= gneg_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      stat.kind       = kind;
      stat.slice_zero = item_ff.slice_val == '0;
      stat.sat        = {1'b0, n_ff} >= {d_ff, 1'b0};
      stat.last       = item_ff.last_gen;
      stat.out_busy   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### hw/rtl/zonotope_generator_slicer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zonotope generator slicer core
// Slices a zonotope one generator at a time and returns weighted sums.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one generator item per handshake (valid high, stall low),
//   together with the query point. Items with last_gen set close a query and
//   produce one rsp_* item; all other items produce nothing.
//   An xy-slice code, an unsupported code or a zero divisor skips the divider
//   and the multiplier: after S_PREP it goes to S_IDLE, or to S_EMIT if it closes.
//   A u/v/r code with a nonzero divisor goes through S_INIT, S_DIV, S_SNAP and
//   S_MUL/S_ACC: the restoring divider works out the lambda fraction bits, one
//   per S_DIV step, then one shared 32x32 multiplier weighs x, y and heading in
//   turn (S_MUL, then S_ACC, for each). A saturated lambda skips the divider.
//   The closing item then loads the result register in S_EMIT, once it is free.
//   Only one item is in flight; req_stall is high until it is done.
//   The result register holds rsp_item stable while rsp_stall is high; the
//   next query's items are still accepted meanwhile, and a later result
//   waits in the controller until the register frees up.
//   Synchronous reset clears accumulators, the xy-seen and bad-dim flags, the
//   xy store and rsp_valid, and sets the lambda-ok flag.
module zonotope_generator_slicer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  zgs_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output zgs_pkg::rsp_item_type rsp_item
);
   import zgs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence the item through classify, divide, snap, weigh, emit
   zgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the item, the divider, multiplier, accumulators and result register
   zgs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
